/* hw/rtl/lcar_pkg.sv */
// Shared types, codes and constants of the load-cell converter reader.
package lcar_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int GAIN_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int FUNC_W     = 2;
    localparam int PULSE_W    = 5;
    localparam int SETTLE_W   = 8;
    localparam int FACTOR_W   = 8;
    localparam int TIMEOUT_W  = 16;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int QUOT_W     = 25;

    localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POLL     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POWER_UP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INIT       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_VALID      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POWER_DOWN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_READS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DIVISOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_SMOOTHED  = 3'd6;

    localparam logic [GAIN_W-1:0] GAIN_A128 = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_A64  = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_B32  = 2'd2;

    localparam logic [PULSE_W-1:0] PULSES_A128 = 5'd25;
    localparam logic [PULSE_W-1:0] PULSES_A64  = 5'd27;
    localparam logic [PULSE_W-1:0] PULSES_B32  = 5'd26;

    localparam logic [GAIN_W-1:0]    RST_GAIN_MODE     = GAIN_A128;
    localparam logic [SETTLE_W-1:0]  RST_SETTLE_READS  = 8'd3;
    localparam logic [FACTOR_W-1:0]  RST_SMOOTHING     = 8'd200;
    localparam logic [DATA_W-1:0]    RST_TARE_OFFSET   = 32'd0;
    localparam logic [DATA_W-1:0]    RST_SCALE_DIVISOR = 32'd256;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_LIMIT = 16'd500;

    typedef struct packed {
        logic take_item;
        logic calc_quot;
        logic calc_step;
        logic calc_smooth;
        logic calc_tare;
        logic div_start;
        logic load_out;
    } lcar_cmd_t;

    typedef struct packed {
        logic div_done;
    } lcar_stat_t;

    function automatic logic [PULSE_W-1:0] pulses_for_gain(input logic [GAIN_W-1:0] gain);
        logic [PULSE_W-1:0] pulses;
        unique case (gain)
            GAIN_A64: pulses = PULSES_A64;
            GAIN_B32: pulses = PULSES_B32;
            default:  pulses = PULSES_A128;
        endcase
        return pulses;
    endfunction

endpackage

/* hw/rtl/lcar_div.sv */
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
module lcar_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [lcar_pkg::DATA_W-1:0]  num,
    input  logic [lcar_pkg::DATA_W-1:0]  den,
    output logic                         done,
    output logic [lcar_pkg::DATA_W-1:0]  quo
);

    localparam int W = lcar_pkg::DATA_W;
    localparam logic [lcar_pkg::DIV_CNT_W-1:0] LAST_STEP =
        lcar_pkg::DIV_CNT_W'(lcar_pkg::DIV_STEPS - 1);

    logic                           busy_reg, busy_next;
    logic                           fin_reg, fin_next;
    logic [lcar_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]                   n_reg, n_next;
    logic [W-1:0]                   rem_reg, rem_next;
    logic [W-1:0]                   d_reg, d_next;
    logic                           neg_reg, neg_next;
    logic                           zero_reg, zero_next;
    logic [W-1:0]                   abs_num;
    logic [W-1:0]                   abs_den;
    logic [W:0]                     trial;

    assign abs_num = num[W-1] ? (W'(0) - num) : num;
    assign abs_den = den[W-1] ? (W'(0) - den) : den;
    assign trial   = {rem_reg, n_reg[W-1]} - {1'b0, d_reg};

    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = abs_num;
            rem_next  = '0;
            d_next    = abs_den;
            neg_next  = num[W-1] ^ den[W-1];
            zero_next = (den == '0);
        end else if (busy_reg) begin
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                n_next   = {n_reg[W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[W-2:0], n_reg[W-1]};
                n_next   = {n_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign done = fin_reg;
    assign quo  = zero_reg ? '0 : (neg_reg ? (W'(0) - n_reg) : n_reg);

endmodule

/* hw/rtl/lcar_datapath.sv */
// Datapath: configuration, reading state, smoothing, tare, divider and result registers.
module lcar_datapath #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lcar_pkg::lcar_cmd_t               cmd,
    output lcar_pkg::lcar_stat_t              stat,
    input  logic                              cfg_wr_en,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcar_pkg::DATA_W-1:0]       cfg_wr_data,
    input  logic [lcar_pkg::FUNC_W-1:0]       in_func,
    input  logic                              in_powered_down,
    input  logic                              in_data_busy,
    input  logic signed [SAMPLE_BITS-1:0]     in_sample,
    output logic                              out_done_res,
    output logic [lcar_pkg::STATUS_W-1:0]     out_status,
    output logic signed [lcar_pkg::DATA_W-1:0] out_raw_value,
    output logic signed [lcar_pkg::DATA_W-1:0] out_smoothed_value,
    output logic signed [lcar_pkg::DATA_W-1:0] out_tared_value,
    output logic signed [lcar_pkg::DATA_W-1:0] out_adjusted_value,
    output logic [lcar_pkg::DATA_W-1:0]       out_timestamp_ms,
    output logic [lcar_pkg::PULSE_W-1:0]      out_clock_pulses
);

    localparam int W   = lcar_pkg::DATA_W;
    localparam int PAD = W - SAMPLE_BITS;

    logic [lcar_pkg::GAIN_W-1:0]    gain_reg;
    logic [lcar_pkg::SETTLE_W-1:0]  settle_reads_reg;
    logic [lcar_pkg::FACTOR_W-1:0]  factor_reg;
    logic [W-1:0]                   tare_reg;
    logic [W-1:0]                   divisor_reg;
    logic [lcar_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                           use_smoothed_reg;

    logic [W-1:0]                   ms_reg, ms_next;
    logic [W-1:0]                   conv_reg, conv_next;
    logic [W-1:0]                   last_ts_reg, last_ts_next;
    logic [W-1:0]                   raw_reg, raw_next;
    logic [W-1:0]                   smoothed_reg, smoothed_next;
    logic [lcar_pkg::SETTLE_W-1:0]  settle_reg, settle_next;
    logic [lcar_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                           done_reg, done_next;
    logic [lcar_pkg::PULSE_W-1:0]   pulses_reg, pulses_next;
    logic                           smooth_pend_reg, smooth_pend_next;

    logic signed [lcar_pkg::QUOT_W-1:0] quot_reg;
    logic [W-1:0]                   step_reg;
    logic [W-1:0]                   tared_reg;
    logic [W-1:0]                   adjusted_reg;

    logic [W-1:0]                   sample_raw;
    logic [W-1:0]                   busy_time;
    logic [lcar_pkg::SETTLE_W-1:0]  settle_eff;
    logic [lcar_pkg::SETTLE_W-1:0]  settle_inc;
    logic [lcar_pkg::STATUS_W-1:0]  status_eff;
    logic signed [W:0]              diff;
    logic signed [W:0]              diff_adj;
    logic signed [W+1:0]            step_full;
    logic [W-1:0]                   selected;
    logic                           div_done;
    logic [W-1:0]                   div_quo;

    assign sample_raw = {in_sample, {PAD{1'b0}}};
    assign busy_time  = ms_reg - conv_reg;
    assign status_eff = (status_reg == lcar_pkg::ST_TIMEOUT) ? lcar_pkg::ST_INIT : status_reg;
    assign settle_eff = (status_reg == lcar_pkg::ST_TIMEOUT) ? '0 : settle_reg;
    assign settle_inc = settle_eff + 1'b1;

    assign diff      = $signed({raw_reg[W-1], raw_reg}) - $signed({smoothed_reg[W-1], smoothed_reg});
    assign diff_adj  = diff[W] ? (diff + (W+1)'(255)) : diff;
    assign step_full = (W+2)'(quot_reg) * (W+2)'($signed({1'b0, factor_reg}));
    assign selected  = use_smoothed_reg ? smoothed_reg : raw_reg;

    always_comb begin
        ms_next          = ms_reg;
        conv_next        = conv_reg;
        last_ts_next     = last_ts_reg;
        raw_next         = raw_reg;
        smoothed_next    = smoothed_reg;
        settle_next      = settle_reg;
        status_next      = status_reg;
        done_next        = done_reg;
        pulses_next      = pulses_reg;
        smooth_pend_next = smooth_pend_reg;
        if (cmd.take_item) begin
            unique case (in_func)
                lcar_pkg::FUNC_TICK: begin
                    ms_next = ms_reg + 1'b1;
                end
                lcar_pkg::FUNC_POWER_UP: begin
                    status_next = lcar_pkg::ST_INIT;
                    settle_next = '0;
                    conv_next   = ms_reg;
                end
                lcar_pkg::FUNC_POLL: begin
                    done_next        = 1'b0;
                    pulses_next      = '0;
                    smooth_pend_next = 1'b0;
                    if (in_powered_down) begin
                        status_next = lcar_pkg::ST_POWER_DOWN;
                        done_next   = 1'b1;
                    end else if (in_data_busy) begin
                        if (busy_time >= W'(timeout_reg)) begin
                            status_next = lcar_pkg::ST_TIMEOUT;
                            done_next   = 1'b1;
                        end
                    end else begin
                        status_next  = status_eff;
                        settle_next  = settle_eff;
                        last_ts_next = conv_reg;
                        raw_next     = sample_raw;
                        pulses_next  = lcar_pkg::pulses_for_gain(gain_reg);
                        conv_next    = ms_reg;
                        if (settle_eff < settle_reads_reg) begin
                            settle_next = settle_inc;
                            if (settle_inc >= settle_reads_reg) begin
                                smoothed_next = sample_raw;
                                status_next   = lcar_pkg::ST_VALID;
                                done_next     = 1'b1;
                            end
                        end else begin
                            status_next      = lcar_pkg::ST_VALID;
                            done_next        = 1'b1;
                            smooth_pend_next = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (cmd.calc_smooth && smooth_pend_reg) begin
            smoothed_next = smoothed_reg + step_reg;
        end
        if (cfg_wr_en && (cfg_index == lcar_pkg::CFG_GAIN_MODE)) begin
            status_next = lcar_pkg::ST_INIT;
            settle_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg         <= lcar_pkg::RST_GAIN_MODE;
            settle_reads_reg <= lcar_pkg::RST_SETTLE_READS;
            factor_reg       <= lcar_pkg::RST_SMOOTHING;
            tare_reg         <= lcar_pkg::RST_TARE_OFFSET;
            divisor_reg      <= lcar_pkg::RST_SCALE_DIVISOR;
            timeout_reg      <= lcar_pkg::RST_TIMEOUT_LIMIT;
            use_smoothed_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lcar_pkg::CFG_GAIN_MODE:     gain_reg <= cfg_wr_data[lcar_pkg::GAIN_W-1:0];
                lcar_pkg::CFG_SETTLE_READS:  settle_reads_reg <=
                                                 cfg_wr_data[lcar_pkg::SETTLE_W-1:0];
                lcar_pkg::CFG_SMOOTHING:     factor_reg <= cfg_wr_data[lcar_pkg::FACTOR_W-1:0];
                lcar_pkg::CFG_TARE_OFFSET:   tare_reg <= cfg_wr_data;
                lcar_pkg::CFG_SCALE_DIVISOR: divisor_reg <= cfg_wr_data;
                lcar_pkg::CFG_TIMEOUT_LIMIT: timeout_reg <= cfg_wr_data[lcar_pkg::TIMEOUT_W-1:0];
                lcar_pkg::CFG_USE_SMOOTHED:  use_smoothed_reg <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_reg          <= '0;
            conv_reg        <= '0;
            last_ts_reg     <= '0;
            raw_reg         <= '0;
            smoothed_reg    <= '0;
            settle_reg      <= '0;
            status_reg      <= lcar_pkg::ST_INIT;
            done_reg        <= 1'b0;
            pulses_reg      <= '0;
            smooth_pend_reg <= 1'b0;
        end else begin
            ms_reg          <= ms_next;
            conv_reg        <= conv_next;
            last_ts_reg     <= last_ts_next;
            raw_reg         <= raw_next;
            smoothed_reg    <= smoothed_next;
            settle_reg      <= settle_next;
            status_reg      <= status_next;
            done_reg        <= done_next;
            pulses_reg      <= pulses_next;
            smooth_pend_reg <= smooth_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_quot) begin
            quot_reg <= diff_adj[W:8];
        end
        if (cmd.calc_step) begin
            step_reg <= step_full[W-1:0];
        end
        if (cmd.calc_tare) begin
            tared_reg <= selected - tare_reg;
        end
        if (div_done) begin
            adjusted_reg <= div_quo;
        end
        if (cmd.load_out) begin
            out_done_res       <= done_reg;
            out_status         <= status_reg;
            out_raw_value      <= raw_reg;
            out_smoothed_value <= smoothed_reg;
            out_tared_value    <= tared_reg;
            out_adjusted_value <= adjusted_reg;
            out_timestamp_ms   <= last_ts_reg;
            out_clock_pulses   <= pulses_reg;
        end
    end

    lcar_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (tared_reg),
        .den     (divisor_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign stat.div_done = div_done;

endmodule

/* hw/rtl/lcar_ctrl.sv */
// Controller state machine that sequences a poll through smoothing, tare and division.
module lcar_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic [lcar_pkg::FUNC_W-1:0]   s_func,
    output logic                          s_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lcar_pkg::lcar_cmd_t           cmd,
    input  lcar_pkg::lcar_stat_t          stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_QUOT = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_TARE = 3'd4;
    localparam logic [2:0] S_DIVS = 3'd5;
    localparam logic [2:0] S_DIVW = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                s_ready       = 1'b1;
                cmd.take_item = s_valid;
                if (s_valid && (s_func == lcar_pkg::FUNC_POLL)) begin
                    state_next = S_QUOT;
                end
            end
            S_QUOT: begin
                cmd.calc_quot = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL: begin
                cmd.calc_step = 1'b1;
                state_next    = S_ADD;
            end
            S_ADD: begin
                cmd.calc_smooth = 1'b1;
                state_next      = S_TARE;
            end
            S_TARE: begin
                cmd.calc_tare = 1'b1;
                state_next    = S_DIVS;
            end
            S_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW: begin
                if (stat.div_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* hw/rtl/load_cell_adc_reader.sv */
// Top level of the load-cell converter reader.
// A tick or a power-up transaction gives no result. A poll gives one result transaction,
// and no new transaction is taken until that result is loaded, which waits while an
// earlier result is still held: the poll passes through three smoothing steps, a tare
// subtract and a radix-2 divider that works out the adjusted value. The result sits in
// an output register, so the block takes further transactions while it waits there.
module load_cell_adc_reader #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcar_pkg::DATA_W-1:0]        cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lcar_pkg::FUNC_W-1:0]        s_func,
    input  logic                               s_powered_down,
    input  logic                               s_data_busy,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_done_res,
    output logic [lcar_pkg::STATUS_W-1:0]      m_status,
    output logic signed [lcar_pkg::DATA_W-1:0] m_raw_value,
    output logic signed [lcar_pkg::DATA_W-1:0] m_smoothed_value,
    output logic signed [lcar_pkg::DATA_W-1:0] m_tared_value,
    output logic signed [lcar_pkg::DATA_W-1:0] m_adjusted_value,
    output logic [lcar_pkg::DATA_W-1:0]        m_timestamp_ms,
    output logic [lcar_pkg::PULSE_W-1:0]       m_clock_pulses
);

    lcar_pkg::lcar_cmd_t  cmd;
    lcar_pkg::lcar_stat_t stat;

    lcar_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    lcar_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data),
        .in_func            (s_func),
        .in_powered_down    (s_powered_down),
        .in_data_busy       (s_data_busy),
        .in_sample          (s_sample),
        .out_done_res       (m_done_res),
        .out_status         (m_status),
        .out_raw_value      (m_raw_value),
        .out_smoothed_value (m_smoothed_value),
        .out_tared_value    (m_tared_value),
        .out_adjusted_value (m_adjusted_value),
        .out_timestamp_ms   (m_timestamp_ms),
        .out_clock_pulses   (m_clock_pulses)
    );

endmodule
